// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/rctm_pkg.sv =====
// Shared types and constants for the tank mixer with arming.
package rctm_pkg;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned WIDTH_W     = 12;
	localparam int unsigned PULSE_W     = 11;
	localparam int unsigned LANES       = 2;

	localparam int unsigned LANE_THR = 0;
	localparam int unsigned LANE_YAW = 1;

	localparam logic [10:0] MID_US     = 11'd1500;
	localparam logic [10:0] OUT_MIN_US = 11'd1000;
	localparam logic [10:0] OUT_MAX_US = 11'd2000;

	// Expo: q = floor((a*a + 250) / 500) = floor(((a*a + 250) >> 2) / 125)
	localparam logic [23:0] EXPO_BIAS   = 24'd250;
	localparam logic [21:0] RECIP_125   = 22'd2147483;
	localparam int unsigned RECIP_SHIFT = 28;
	localparam logic [20:0] DIV_125     = 21'd125;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEADBAND          = 4'd0,
		REG_ARM_THRESHOLD     = 4'd1,
		REG_ARM_POLARITY      = 4'd2,
		REG_NEUTRAL_TOLERANCE = 4'd3,
		REG_LEFT_TRIM         = 4'd4,
		REG_RIGHT_TRIM        = 4'd5,
		REG_INVERT_MASK       = 4'd6,
		REG_EXPO_ENABLE       = 4'd7
	} cfg_reg_t;

	typedef logic signed [12:0] offset_t;
	typedef logic signed [14:0] shaped_t;

endpackage

// ===== sv/rc_tank_mixer_with_arming_top.sv =====
// Tank mixer top level: input register, arming update, expo divide, mix and clamp.
// An accepted input transaction moves through stages 1 to 4 and then the result register.
// Throughput: one transaction per cycle; the five register stages advance together
// unless the result register is stalled, and empty stages fill behind a stall.
// The expo divide by 500 is a reciprocal multiply plus a one-step correction.
// Reset (arst_n low): disarmed, lockout clear, pipeline empty, registers at defaults.
module rc_tank_mixer_with_arming_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rctm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rctm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rctm_pkg::WIDTH_W-1:0]   throttle_width,
	input  logic [rctm_pkg::WIDTH_W-1:0]   yaw_width,
	input  logic [rctm_pkg::WIDTH_W-1:0]   switch_width,
	input  logic                           throttle_fresh,
	input  logic                           yaw_fresh,
	input  logic                           switch_fresh,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rctm_pkg::PULSE_W-1:0]   left_pulse,
	output logic [rctm_pkg::PULSE_W-1:0]   right_pulse,
	output logic                           is_armed,
	output logic                           signal_ok
);
	import rctm_pkg::*;

	// configuration
	logic [7:0]        deadband_q;
	logic [11:0]       arm_threshold_q;
	logic              arm_polarity_q;
	logic [7:0]        neutral_tol_q;
	logic signed [7:0] left_trim_q;
	logic signed [7:0] right_trim_q;
	logic [1:0]        invert_mask_q;
	logic              expo_enable_q;

	// arming state
	logic armed_q;
	logic lockout_q;

	// stage valids and enables
	logic v1_s1, v2_s2, v3_s3, v4_s4, out_v_q;
	logic en1, en2, en3, en4, en_out;

	// stage 1: captured input
	logic [WIDTH_W-1:0] width_s1 [LANES];
	logic [WIDTH_W-1:0] switch_s1;
	logic               ok_s1;

	// stage 2
	offset_t     off_s2  [LANES];
	logic        zero_s2 [LANES];
	logic [20:0] m_s2    [LANES];
	logic        armed_s2, ok_s2;

	// stage 3
	offset_t     off_s3  [LANES];
	logic        zero_s3 [LANES];
	logic [20:0] m_s3    [LANES];
	logic [13:0] q0_s3   [LANES];
	logic        armed_s3, ok_s3;

	// stage 4
	shaped_t shaped_s4 [LANES];
	logic    armed_s4, ok_s4;

	// result register
	logic [PULSE_W-1:0] left_q, right_q;
	logic               armed_out_q, ok_out_q;

	// combinational
	offset_t     off_c  [LANES];
	logic [11:0] mag_c  [LANES];
	logic        zero_c [LANES];
	logic [20:0] m_c    [LANES];
	logic        engaged_c, neutral_c, armed_next, lockout_next;
	logic [13:0] q0_c   [LANES];
	logic [20:0] q0x125_c [LANES];
	logic [20:0] rem_c  [LANES];
	logic [13:0] q_c    [LANES];
	shaped_t     shaped_c [LANES];
	logic signed [15:0] left_mix_c, right_mix_c;
	logic signed [16:0] left_sum_c, right_sum_c;
	logic [PULSE_W-1:0] left_c, right_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q      <= 8'd25;
			arm_threshold_q <= 12'd1500;
			arm_polarity_q  <= 1'b0;
			neutral_tol_q   <= 8'd60;
			left_trim_q     <= 8'sd0;
			right_trim_q    <= 8'sd0;
			invert_mask_q   <= 2'd0;
			expo_enable_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEADBAND:          deadband_q      <= cfg_data[7:0];
				REG_ARM_THRESHOLD:     arm_threshold_q <= cfg_data[11:0];
				REG_ARM_POLARITY:      arm_polarity_q  <= cfg_data[0];
				REG_NEUTRAL_TOLERANCE: neutral_tol_q   <= cfg_data[7:0];
				REG_LEFT_TRIM:         left_trim_q     <= $signed(cfg_data[7:0]);
				REG_RIGHT_TRIM:        right_trim_q    <= $signed(cfg_data[7:0]);
				REG_INVERT_MASK:       invert_mask_q   <= cfg_data[1:0];
				REG_EXPO_ENABLE:       expo_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance a stage when the one after it is empty or advancing
	assign en_out   = !out_v_q || out_ready;
	assign en4      = !v4_s4 || en_out;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)    v1_s1   <= in_valid;
			if (en2)    v2_s2   <= v1_s1;
			if (en3)    v3_s3   <= v2_s2;
			if (en4)    v4_s4   <= v3_s3;
			if (en_out) out_v_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			width_s1[LANE_THR] <= throttle_width;
			width_s1[LANE_YAW] <= yaw_width;
			switch_s1          <= switch_width;
			ok_s1              <= throttle_fresh && yaw_fresh && switch_fresh;
		end
	end

	// stage 1 -> 2: offsets, deadband, squares, arming update
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			off_c[i]  = $signed({1'b0, width_s1[i]}) - $signed({2'b00, MID_US});
			mag_c[i]  = off_c[i][12] ? 12'(-off_c[i]) : 12'(off_c[i]);
			zero_c[i] = mag_c[i] < 12'(deadband_q);
			m_c[i]    = 21'((24'(mag_c[i]) * 24'(mag_c[i]) + EXPO_BIAS) >> 2);
		end
		engaged_c = arm_polarity_q ? (switch_s1 > arm_threshold_q)
		                           : (switch_s1 < arm_threshold_q);
		neutral_c = (mag_c[LANE_THR] < 12'(neutral_tol_q))
		         && (mag_c[LANE_YAW] < 12'(neutral_tol_q));
		armed_next   = armed_q;
		lockout_next = lockout_q;
		priority if (!ok_s1 || !engaged_c) begin
			armed_next   = 1'b0;
			lockout_next = 1'b0;
		end else if (!armed_q && !lockout_q) begin
			armed_next   = neutral_c;
			lockout_next = !neutral_c;
		end else begin
			// hold while armed or locked out
			armed_next   = armed_q;
			lockout_next = lockout_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			lockout_q <= 1'b0;
		end else if (en2 && v1_s1) begin
			armed_q   <= armed_next;
			lockout_q <= lockout_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			off_s2   <= off_c;
			zero_s2  <= zero_c;
			m_s2     <= m_c;
			armed_s2 <= armed_next;
			ok_s2    <= ok_s1;
		end
	end

	// stage 2 -> 3: reciprocal multiply, estimate is exact or one low
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			q0_c[i] = 14'((43'(m_s2[i]) * 43'(RECIP_125)) >> RECIP_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			off_s3   <= off_s2;
			zero_s3  <= zero_s2;
			m_s3     <= m_s2;
			q0_s3    <= q0_c;
			armed_s3 <= armed_s2;
			ok_s3    <= ok_s2;
		end
	end

	// stage 3 -> 4: correct quotient, restore sign, pick curve
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			q0x125_c[i] = (21'(q0_s3[i]) << 7) - (21'(q0_s3[i]) << 2) + 21'(q0_s3[i]);
			rem_c[i]    = m_s3[i] - q0x125_c[i];
			q_c[i]      = q0_s3[i] + 14'(rem_c[i] >= DIV_125);
			priority if (zero_s3[i])
				shaped_c[i] = '0;
			else if (expo_enable_q)
				shaped_c[i] = off_s3[i][12] ? -shaped_t'({1'b0, q_c[i]})
				                            : shaped_t'({1'b0, q_c[i]});
			else
				shaped_c[i] = 15'(off_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3_s3) begin
			shaped_s4 <= shaped_c;
			armed_s4  <= armed_s3;
			ok_s4     <= ok_s3;
		end
	end

	// stage 4 -> result: mix, invert, trim, clamp; neutral pulses when disarmed
	always_comb begin
		left_mix_c  = 16'(shaped_s4[LANE_THR]) + 16'(shaped_s4[LANE_YAW]);
		right_mix_c = 16'(shaped_s4[LANE_THR]) - 16'(shaped_s4[LANE_YAW]);
		if (invert_mask_q[0]) left_mix_c  = -left_mix_c;
		if (invert_mask_q[1]) right_mix_c = -right_mix_c;
		left_sum_c  = 17'(left_mix_c) + $signed({6'd0, MID_US}) + 17'(left_trim_q);
		right_sum_c = 17'(right_mix_c) + $signed({6'd0, MID_US}) + 17'(right_trim_q);
		priority if (!armed_s4)
			left_c = MID_US;
		else if (left_sum_c < $signed({6'd0, OUT_MIN_US}))
			left_c = OUT_MIN_US;
		else if (left_sum_c > $signed({6'd0, OUT_MAX_US}))
			left_c = OUT_MAX_US;
		else
			left_c = left_sum_c[PULSE_W-1:0];
		priority if (!armed_s4)
			right_c = MID_US;
		else if (right_sum_c < $signed({6'd0, OUT_MIN_US}))
			right_c = OUT_MIN_US;
		else if (right_sum_c > $signed({6'd0, OUT_MAX_US}))
			right_c = OUT_MAX_US;
		else
			right_c = right_sum_c[PULSE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_out && v4_s4) begin
			left_q      <= left_c;
			right_q     <= right_c;
			armed_out_q <= armed_s4;
			ok_out_q    <= ok_s4;
		end
	end

	assign out_valid   = out_v_q;
	assign left_pulse  = left_q;
	assign right_pulse = right_q;
	assign is_armed    = armed_out_q;
	assign signal_ok   = ok_out_q;

endmodule

// ===== sv/rctm_checker.sv =====
// Port-level checker for the tank mixer, bound to the top level.
`include "assert_macros.svh"

module rctm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rctm_pkg::PULSE_W-1:0] left_pulse,
	input logic [rctm_pkg::PULSE_W-1:0] right_pulse,
	input logic                         is_armed,
	input logic                         signal_ok
);
	import rctm_pkg::*;

	// disarmed results are neutral on both sides
	`ASSERT_ALWAYS(a_disarmed_neutral, clk, arst_n, !out_valid || is_armed || (left_pulse == MID_US && right_pulse == MID_US))

	// arming needs a good signal in the same transaction
	`ASSERT_ALWAYS(a_armed_needs_signal, clk, arst_n, !out_valid || !is_armed || signal_ok)

	// pulses stay inside the servo window
	`ASSERT_ALWAYS(a_pulse_window, clk, arst_n, !out_valid || (left_pulse >= OUT_MIN_US && left_pulse <= OUT_MAX_US && right_pulse >= OUT_MIN_US && right_pulse <= OUT_MAX_US))

	// hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(left_pulse) && $stable(right_pulse) && $stable(is_armed) && $stable(signal_ok))

endmodule

bind rc_tank_mixer_with_arming_top rctm_checker u_rctm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_pulse  (left_pulse),
	.right_pulse (right_pulse),
	.is_armed    (is_armed),
	.signal_ok   (signal_ok)
);
